// ===== rtl/tlfq_pkg.sv =====
`timescale 1ns / 1ps

package tlfq_pkg;

    // Default number of entries in each job queue.
    localparam int QUEUE_DEPTH = 64;

    // Field widths of a job.
    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int CNT_W   = 16;

    // Saturation value of the tick counters.
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // Operation codes of an input beat.
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_TICK      = 2'd0;
    localparam logic [1:0] ST_ACCEPTED  = 2'd1;
    localparam logic [1:0] ST_DROP_ZERO = 2'd2;
    localparam logic [1:0] ST_DROP_FULL = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_QUANTUM_LOW    = 2'd0;
    localparam logic [1:0] CFG_QUANTUM_HIGH   = 2'd1;
    localparam logic [1:0] CFG_ELEVATE_ENABLE = 2'd2;
    localparam logic [1:0] CFG_ELEVATE_PERIOD = 2'd3;

    // Configuration values after reset.
    localparam logic [15:0] RST_QUANTUM_LOW    = 16'd4;
    localparam logic [15:0] RST_QUANTUM_HIGH   = 16'd7;
    localparam logic        RST_ELEVATE_ENABLE = 1'b0;
    localparam logic [15:0] RST_ELEVATE_PERIOD = 16'd4;

    // One queued or running job.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               prio;
        logic [BURST_W-1:0] burst;
        logic [CNT_W-1:0]   served;
    } t_job;

    // Commands from the sequencer to one job queue.
    typedef struct packed {
        logic push;
        logic pop;
        t_job wdata;
    } t_ring_ctl;

endpackage

// ===== rtl/tlfq_ring.sv =====
`timescale 1ns / 1ps

module tlfq_ring #(
    parameter int DEPTH = tlfq_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tlfq_pkg::t_ring_ctl       i_ctl,
    output tlfq_pkg::t_job            o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int NUM_W = $clog2(DEPTH + 1);

    tlfq_pkg::t_job r_mem [DEPTH];
    tlfq_pkg::t_job r_rdata;

    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [NUM_W-1:0] r_count;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;
    logic [NUM_W-1:0] n_count;

    // Pointer advance with wrap at the last entry.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.pop) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Job store: one write port at the tail, one registered read at the head.
    // Head and tail meet when both are used in one cycle only if the queue is full.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_ctl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_count != '0))
        else $error("pop from an empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |-> (r_count != NUM_W'(DEPTH)))
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NUM_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== rtl/two_level_feedback_queue_scheduler.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                       Beat
// input     in         i_valid / o_stall               operation, job fields
// output    out        o_valid / i_stall               status, running job, idle flag
// config    in         i_cfg_valid / o_cfg_ready       register index, data
//
// An arrival passes through S_IDLE and S_DONE; a tick passes through S_TICK, S_ELEV
// when the low queue is elevated, S_PICK, S_LOAD when a job is picked, and S_DONE.
// S_ELEV moves the low-queue jobs into the high queue; the queue reads are registered.
// Reset is synchronous and active low; both queues are empty after it.
// A new beat is taken while an earlier result still waits at the output
// register; a result that meets a full output register holds until it drains.

module two_level_feedback_queue_scheduler #(
    parameter int QUEUE_DEPTH = tlfq_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_job_id,
    input  logic        i_priority_level,
    input  logic [15:0] i_burst_length,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_status,
    output logic        o_running_valid,
    output logic [15:0] o_run_id,
    output logic        o_all_idle,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NUM_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TICK = 6'b000010,
        S_ELEV = 6'b000100,
        S_PICK = 6'b001000,
        S_LOAD = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [15:0] r_q_low;
    logic [15:0] r_q_high;
    logic        r_elev_en;
    logic [15:0] r_elev_period;

    // Scheduler state.
    tlfq_pkg::t_job   r_run;
    tlfq_pkg::t_job   n_run;
    logic             r_run_valid;
    logic             n_run_valid;
    logic [15:0]      r_q_elapsed;
    logic [15:0]      n_q_elapsed;
    logic [15:0]      r_e_elapsed;
    logic [15:0]      n_e_elapsed;
    logic [NUM_W-1:0] r_held;
    logic [NUM_W-1:0] n_held;
    logic             r_is_tick;
    logic             n_is_tick;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             r_pick_low;
    logic             n_pick_low;
    logic             r_mv_pend;
    logic             n_mv_pend;

    // Output register.
    logic        r_out_valid;
    logic        n_out_valid;
    logic        out_load;
    logic [1:0]  r_out_status;
    logic        r_out_run_valid;
    logic [15:0] r_out_run_id;
    logic        r_out_idle;

    // Queue interfaces.
    tlfq_pkg::t_ring_ctl high_ctl;
    tlfq_pkg::t_ring_ctl low_ctl;
    tlfq_pkg::t_job      high_rdata;
    tlfq_pkg::t_job      low_rdata;
    logic [NUM_W-1:0]    high_count;
    logic [NUM_W-1:0]    low_count;

    logic [15:0]    quantum;
    tlfq_pkg::t_job arrive_job;

    tlfq_ring #(
        .DEPTH(QUEUE_DEPTH)
    ) u_high_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (high_ctl),
        .o_rdata(high_rdata),
        .o_count(high_count)
    );

    tlfq_ring #(
        .DEPTH(QUEUE_DEPTH)
    ) u_low_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (low_ctl),
        .o_rdata(low_rdata),
        .o_count(low_count)
    );

    // Configuration writes are taken at any time.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_low       <= tlfq_pkg::RST_QUANTUM_LOW;
            r_q_high      <= tlfq_pkg::RST_QUANTUM_HIGH;
            r_elev_en     <= tlfq_pkg::RST_ELEVATE_ENABLE;
            r_elev_period <= tlfq_pkg::RST_ELEVATE_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlfq_pkg::CFG_QUANTUM_LOW:    r_q_low       <= i_cfg_data;
                tlfq_pkg::CFG_QUANTUM_HIGH:   r_q_high      <= i_cfg_data;
                tlfq_pkg::CFG_ELEVATE_ENABLE: r_elev_en     <= i_cfg_data[0];
                tlfq_pkg::CFG_ELEVATE_PERIOD: r_elev_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);

    assign quantum = (r_run.prio == 1'b0) ? r_q_high : r_q_low;

    assign arrive_job = '{id: i_job_id, prio: i_priority_level,
                          burst: i_burst_length, served: '0};

    // Sequencer: arrival, release or feedback, elevation, pick, report.
    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_run_valid = r_run_valid;
        n_q_elapsed = r_q_elapsed;
        n_e_elapsed = r_e_elapsed;
        n_held      = r_held;
        n_is_tick   = r_is_tick;
        n_status    = r_status;
        n_pick_low  = r_pick_low;
        n_mv_pend   = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        out_load    = 1'b0;
        high_ctl    = '{push: 1'b0, pop: 1'b0, wdata: arrive_job};
        low_ctl     = '{push: 1'b0, pop: 1'b0, wdata: r_run};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == tlfq_pkg::OP_ARRIVE) begin
                        n_is_tick = 1'b0;
                        n_state   = S_DONE;
                        if (i_burst_length == '0) begin
                            n_status = tlfq_pkg::ST_DROP_ZERO;
                        end else if (r_held >= NUM_W'(QUEUE_DEPTH)) begin
                            n_status = tlfq_pkg::ST_DROP_FULL;
                        end else begin
                            n_status      = tlfq_pkg::ST_ACCEPTED;
                            high_ctl.push = 1'b1;
                            n_held        = r_held + 1'b1;
                        end
                    end else begin
                        n_is_tick = 1'b1;
                        n_status  = tlfq_pkg::ST_TICK;
                        n_state   = S_TICK;
                    end
                end
            end

            S_TICK: begin
                // Release a finished job or feed an expired one back.
                if (r_run_valid) begin
                    if (r_run.served >= r_run.burst) begin
                        n_run_valid = 1'b0;
                        n_held      = r_held - 1'b1;
                        n_q_elapsed = '0;
                    end else if (r_q_elapsed >= quantum) begin
                        low_ctl.push = 1'b1;
                        n_run_valid  = 1'b0;
                        n_q_elapsed  = '0;
                    end
                end
                if (r_elev_en && (r_e_elapsed >= r_elev_period)) begin
                    n_e_elapsed = '0;
                    n_state     = S_ELEV;
                end else begin
                    n_state = S_PICK;
                end
            end

            S_ELEV: begin
                // Stream the low queue into the high queue, one job a cycle.
                high_ctl.wdata = low_rdata;
                high_ctl.push  = r_mv_pend;
                if (low_count != '0) begin
                    low_ctl.pop = 1'b1;
                    n_mv_pend   = 1'b1;
                end else begin
                    n_state = S_PICK;
                end
            end

            S_PICK: begin
                n_state = S_DONE;
                if (!r_run_valid) begin
                    if (high_count != '0) begin
                        high_ctl.pop = 1'b1;
                        n_pick_low   = 1'b0;
                        n_state      = S_LOAD;
                    end else if (low_count != '0) begin
                        low_ctl.pop = 1'b1;
                        n_pick_low  = 1'b1;
                        n_state     = S_LOAD;
                    end
                end
            end

            S_LOAD: begin
                n_run       = r_pick_low ? low_rdata : high_rdata;
                n_run_valid = 1'b1;
                n_state     = S_DONE;
            end

            S_DONE: begin
                // Report, then advance the tick counters.
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_is_tick) begin
                        if (r_e_elapsed != tlfq_pkg::CNT_MAX) begin
                            n_e_elapsed = r_e_elapsed + 1'b1;
                        end
                        if (r_run_valid) begin
                            if (r_run.served != tlfq_pkg::CNT_MAX) begin
                                n_run.served = r_run.served + 1'b1;
                            end
                            if (r_q_elapsed != tlfq_pkg::CNT_MAX) begin
                                n_q_elapsed = r_q_elapsed + 1'b1;
                            end
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_valid <= 1'b0;
            r_q_elapsed <= '0;
            r_e_elapsed <= '0;
            r_held      <= '0;
            r_is_tick   <= 1'b0;
            r_mv_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_q_elapsed <= n_q_elapsed;
            r_e_elapsed <= n_e_elapsed;
            r_held      <= n_held;
            r_is_tick   <= n_is_tick;
            r_mv_pend   <= n_mv_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_run      <= n_run;
        r_status   <= n_status;
        r_pick_low <= n_pick_low;
        if (out_load) begin
            r_out_status    <= r_status;
            r_out_run_valid <= r_run_valid;
            r_out_run_id    <= r_run_valid ? r_run.id : '0;
            r_out_idle      <= !r_run_valid && (high_count == '0) && (low_count == '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_status = r_out_status;
    assign o_running_valid = r_out_run_valid;
    assign o_run_id        = r_out_run_id;
    assign o_all_idle      = r_out_idle;

endmodule
